// ===== rtl/token_lexer_macros.svh =====
// assertion macros shared by the token lexer modules
`ifndef TOKEN_LEXER_MACROS_SVH
`define TOKEN_LEXER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define TL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define TL_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TL_ASSERT(label, prop, msg)
`define TL_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== rtl/tl_pkg.sv =====
// shared types, codes and helpers of the token lexer
`timescale 1ns / 1ps

package tl_pkg;

  // source offsets wrap at this width
  localparam int POS_W = 16;
  typedef logic [POS_W-1:0] pos_t;

  // byte classes decided by the front part
  typedef enum logic [3:0] {
    CLS_EOS,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_QUOTE,
    CLS_DIGIT,
    CLS_WORD,
    CLS_DOT,
    CLS_OP,
    CLS_OTHER
  } tl_class_t;

  // one classified item
  typedef struct packed {
    tl_class_t  cls;
    logic [7:0] ch;
    logic [2:0] op;
  } tl_item_t;

  // token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_INT     = 5'd1;
  localparam logic [4:0] KIND_FLOAT   = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_BOOL    = 5'd4;
  localparam logic [4:0] KIND_ID      = 5'd5;
  localparam logic [4:0] KIND_PRINT   = 5'd6;
  localparam logic [4:0] KIND_WHILE   = 5'd7;
  localparam logic [4:0] KIND_IF      = 5'd8;
  localparam logic [4:0] KIND_ELSE    = 5'd9;
  localparam logic [4:0] KIND_OP_BASE = 5'd10;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED   = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

  // one result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [62:0] ival;
    logic [5:0]  frac;
    logic        bval;
    logic [15:0] tstart;
    logic [15:0] tlen;
    logic        last;
  } tl_res_t;

  // result writes from the engine into the output queue
  typedef struct packed {
    logic first;
    logic second;
  } tl_push_t;

  // offset or length cut or widened to the 16 bit result fields
  function automatic logic [15:0] text16(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage

// ===== rtl/token_lexer.sv =====
// top level of the streaming token lexer
`timescale 1ns / 1ps

// channel  | handshake    | payload
// input    | push / full  | in_command, in_ch
// result   | empty / pop  | out_token_kind, out_error_code, out_int_value, out_frac_digits,
//          |              | out_bool_value, out_text_start, out_text_length, out_last_of_run
//
// one byte a cycle enters while full is low; results are read from the registered result queue
// the result port moves one item a cycle while pop is high, so a byte that closes a token
// and gives a second result is read out as two items, buffered in the four entry result queue
// full rises when the two entry front queue holds two items; the scanner waits
// until the result queue has room for two results
// reset is synchronous and clears both queues and the scanner state

module token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic [7:0]  in_ch,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_token_kind,
  output logic [1:0]  out_error_code,
  output logic [62:0] out_int_value,
  output logic [5:0]  out_frac_digits,
  output logic        out_bool_value,
  output logic [15:0] out_text_start,
  output logic [15:0] out_text_length,
  output logic        out_last_of_run
);
  import tl_pkg::*;

  tl_item_t item;
  logic     item_valid;
  logic     item_pop;
  logic     room;
  tl_push_t res_push;
  tl_res_t  res0, res1, head;

  // classify and buffer incoming items
  tl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_command (in_command),
    .in_ch      (in_ch),
    .full       (full),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  // scanner
  tl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .room       (room),
    .push       (res_push),
    .res0       (res0),
    .res1       (res1)
  );

  // result buffering
  tl_out_queue u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .res0  (res0),
    .res1  (res1),
    .room  (room),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign out_token_kind  = head.kind;
  assign out_error_code  = head.err;
  assign out_int_value   = head.ival;
  assign out_frac_digits = head.frac;
  assign out_bool_value  = head.bval;
  assign out_text_start  = head.tstart;
  assign out_text_length = head.tlen;
  assign out_last_of_run = head.last;

endmodule

// ===== rtl/tl_front.sv =====
// front part: accepts items, classifies each byte, holds a two entry queue
`timescale 1ns / 1ps

module tl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              in_command,
  input  logic [7:0]        in_ch,
  output logic              full,
  output logic              item_valid,
  input  logic              item_pop,
  output tl_pkg::tl_item_t  item
);
  import tl_pkg::*;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] OP_CHARS [8] = '{8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h3B};

  tl_item_t   store_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  tl_item_t   cls_item;
  logic       accept;
  logic       take;
  logic       op_hit;
  logic [2:0] op_idx;

  // byte classification
  always_comb begin
    op_hit = 1'b0;
    op_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (in_ch == OP_CHARS[i]) begin
        op_hit = 1'b1;
        op_idx = 3'(i);
      end
    end
    cls_item.ch = in_ch;
    cls_item.op = op_idx;
    if (in_command) begin
      cls_item.cls = CLS_EOS;
    end else if (in_ch == CH_NL) begin
      cls_item.cls = CLS_NEWLINE;
    end else if (in_ch == 8'h20 || (in_ch >= 8'h09 && in_ch <= 8'h0D)) begin
      cls_item.cls = CLS_SPACE;
    end else if (in_ch == CH_QUOTE) begin
      cls_item.cls = CLS_QUOTE;
    end else if (in_ch >= 8'h30 && in_ch <= 8'h39) begin
      cls_item.cls = CLS_DIGIT;
    end else if ((in_ch >= 8'h61 && in_ch <= 8'h7A) || (in_ch >= 8'h41 && in_ch <= 8'h5A)
                 || in_ch == CH_UNDER) begin
      cls_item.cls = CLS_WORD;
    end else if (in_ch == CH_DOT) begin
      cls_item.cls = CLS_DOT;
    end else if (op_hit) begin
      cls_item.cls = CLS_OP;
    end else begin
      cls_item.cls = CLS_OTHER;
    end
  end

  // queue control
  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = store_r[rp_r];
  assign accept     = push && !full;
  assign take       = item_pop && item_valid;

  always_comb begin
    wp_nxt  = accept ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(accept) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[wp_r] <= cls_item;
    end
  end

endmodule

// ===== rtl/tl_engine.sv =====
// back part: scanner state machine that turns classified items into results
`timescale 1ns / 1ps
`include "token_lexer_macros.svh"

module tl_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  tl_pkg::tl_item_t  item,
  input  logic              item_valid,
  output logic              item_pop,
  input  logic              room,
  output tl_pkg::tl_push_t  push,
  output tl_pkg::tl_res_t   res0,
  output tl_pkg::tl_res_t   res1
);
  import tl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_ERROR
  } mode_t;

  localparam logic [39:0] KW_PRINT = 40'h7072696E74;
  localparam logic [39:0] KW_WHILE = 40'h7768696C65;
  localparam logic [39:0] KW_IF    = 40'h0000006966;
  localparam logic [39:0] KW_ELSE  = 40'h00656C7365;
  localparam logic [39:0] KW_TRUE  = 40'h0074727565;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;
  localparam logic [39:0] KW_LONG  = 40'hFFFFFFFFFF;
  localparam logic [62:0] VAL_MAX  = 63'h7FFFFFFFFFFFFFFF;
  // largest accumulator that still takes a digit without passing the maximum
  localparam logic [62:0] SAT_LIM_LO = 63'd922337203685477580;
  localparam logic [62:0] SAT_LIM_HI = 63'd922337203685477579;

  mode_t       mode_r, mode_nxt;
  pos_t        pos_r, pos_nxt;
  pos_t        start_r, start_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic        dot_r, dot_nxt;
  logic [5:0]  frac_r, frac_nxt;
  logic [39:0] kw_r, kw_nxt;

  tl_res_t     num_res, id_res, close_res, fresh_res;
  logic        close_vld, fresh_vld, relex;
  logic [3:0]  digit;
  logic [62:0] acc_ext;
  logic        acc_sat;
  pos_t        text_len;

  assign item_pop = item_valid && room;
  assign digit    = item.ch[3:0];
  assign text_len = pos_t'(pos_r - start_r);

  // accumulator step: times ten plus digit, saturating
  always_comb begin
    acc_sat = (digit <= 4'd7) ? (acc_r > SAT_LIM_LO) : (acc_r > SAT_LIM_HI);
    acc_ext = (acc_r << 3) + (acc_r << 1) + 63'(digit);
  end

  // pending number as a result
  always_comb begin
    num_res      = '0;
    num_res.kind = dot_r ? KIND_FLOAT : KIND_INT;
    num_res.ival = acc_r;
    num_res.frac = dot_r ? frac_r : 6'd0;
  end

  // pending identifier with keyword match
  always_comb begin
    id_res        = '0;
    id_res.tstart = text16(start_r);
    id_res.tlen   = text16(text_len);
    if (kw_r == KW_PRINT) begin
      id_res.kind = KIND_PRINT;
    end else if (kw_r == KW_WHILE) begin
      id_res.kind = KIND_WHILE;
    end else if (kw_r == KW_IF) begin
      id_res.kind = KIND_IF;
    end else if (kw_r == KW_ELSE) begin
      id_res.kind = KIND_ELSE;
    end else if (kw_r == KW_TRUE) begin
      id_res.kind = KIND_BOOL;
      id_res.bval = 1'b1;
    end else if (kw_r == KW_FALSE) begin
      id_res.kind = KIND_BOOL;
    end else begin
      id_res.kind = KIND_ID;
    end
  end

  // next state and results of the item taken this cycle
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    acc_nxt   = acc_r;
    dot_nxt   = dot_r;
    frac_nxt  = frac_r;
    kw_nxt    = kw_r;
    close_vld = 1'b0;
    fresh_vld = 1'b0;
    close_res = '0;
    fresh_res = '0;
    relex     = 1'b0;
    if (item_pop) begin
      if (item.cls == CLS_EOS) begin
        // end of source: flush pending token, report unless in error mode, back to reset state
        unique case (mode_r)
          MODE_ERROR: begin
          end
          MODE_STRING: begin
            fresh_vld     = 1'b1;
            fresh_res.err = ERR_UNCLOSED;
          end
          MODE_NUMBER: begin
            close_vld = 1'b1;
            close_res = num_res;
            fresh_vld = 1'b1;
          end
          MODE_IDENT: begin
            close_vld = 1'b1;
            close_res = id_res;
            fresh_vld = 1'b1;
          end
          default: begin
            fresh_vld = 1'b1;
          end
        endcase
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        acc_nxt   = '0;
        dot_nxt   = 1'b0;
        frac_nxt  = '0;
        kw_nxt    = '0;
      end else begin
        unique case (mode_r)
          MODE_ERROR: begin
          end
          MODE_STRING: begin
            pos_nxt = pos_t'(pos_r + 1'b1);
            if (item.cls == CLS_QUOTE) begin
              fresh_vld        = 1'b1;
              fresh_res.kind   = KIND_STRING;
              fresh_res.tstart = text16(start_r);
              fresh_res.tlen   = text16(text_len);
              mode_nxt         = MODE_IDLE;
            end else if (item.cls == CLS_NEWLINE) begin
              fresh_vld     = 1'b1;
              fresh_res.err = ERR_UNCLOSED;
              mode_nxt      = MODE_ERROR;
            end
          end
          MODE_NUMBER: begin
            pos_nxt = pos_t'(pos_r + 1'b1);
            if (item.cls == CLS_DIGIT) begin
              acc_nxt = acc_sat ? VAL_MAX : acc_ext;
              if (dot_r && frac_r != 6'd63) begin
                frac_nxt = frac_r + 6'd1;
              end
            end else if (item.cls == CLS_DOT && !dot_r) begin
              dot_nxt = 1'b1;
            end else begin
              close_vld = 1'b1;
              close_res = num_res;
              relex     = 1'b1;
            end
          end
          MODE_IDENT: begin
            pos_nxt = pos_t'(pos_r + 1'b1);
            if (item.cls == CLS_WORD || item.cls == CLS_DIGIT) begin
              if (kw_r[39:32] == 8'd0 && kw_r != '0) begin
                kw_nxt = {kw_r[31:0], item.ch};
              end else begin
                kw_nxt = KW_LONG;
              end
            end else begin
              close_vld = 1'b1;
              close_res = id_res;
              relex     = 1'b1;
            end
          end
          default: begin
            pos_nxt = pos_t'(pos_r + 1'b1);
            relex   = 1'b1;
          end
        endcase
        // fresh lexing of the byte from the idle mode
        if (relex) begin
          mode_nxt = MODE_IDLE;
          unique case (item.cls) inside
            CLS_SPACE, CLS_NEWLINE: begin
            end
            CLS_QUOTE: begin
              mode_nxt  = MODE_STRING;
              start_nxt = pos_t'(pos_r + 1'b1);
            end
            CLS_DIGIT: begin
              mode_nxt = MODE_NUMBER;
              acc_nxt  = 63'(digit);
              dot_nxt  = 1'b0;
              frac_nxt = '0;
            end
            CLS_WORD: begin
              mode_nxt  = MODE_IDENT;
              start_nxt = pos_r;
              kw_nxt    = 40'(item.ch);
            end
            CLS_OP: begin
              fresh_vld      = 1'b1;
              fresh_res.kind = 5'(KIND_OP_BASE + 5'(item.op));
            end
            default: begin
              fresh_vld     = 1'b1;
              fresh_res.err = ERR_UNEXPECTED;
              mode_nxt      = MODE_ERROR;
            end
          endcase
        end
      end
    end
  end

  // results in order: closed token first, then the fresh one
  always_comb begin
    push.first  = close_vld || fresh_vld;
    push.second = close_vld && fresh_vld;
    res0        = close_vld ? close_res : fresh_res;
    res0.last   = !push.second;
    res1        = fresh_res;
    res1.last   = 1'b1;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      acc_r   <= '0;
      dot_r   <= 1'b0;
      frac_r  <= '0;
      kw_r    <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      acc_r   <= acc_nxt;
      dot_r   <= dot_nxt;
      frac_r  <= frac_nxt;
      kw_r    <= kw_nxt;
    end
  end

  // checks
  `TL_ASSERT(a_error_sticky, (item_pop && mode_r == MODE_ERROR && item.cls != CLS_EOS) |=> mode_r == MODE_ERROR, "error mode left before end of source")
  `TL_ASSERT(a_eos_clear, (item_pop && item.cls == CLS_EOS) |=> (mode_r == MODE_IDLE && pos_r == '0), "end of source did not clear the scanner")
  `TL_ASSERT(a_pair_last, push.second |-> (push.first && !res0.last && res1.last), "last flag wrong on a result pair")

endmodule

// ===== rtl/tl_out_queue.sv =====
// result queue: four entries, up to two writes and one read a cycle
`timescale 1ns / 1ps
`include "token_lexer_macros.svh"

module tl_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  tl_pkg::tl_push_t  push,
  input  tl_pkg::tl_res_t   res0,
  input  tl_pkg::tl_res_t   res1,
  output logic              room,
  input  logic              pop,
  output logic              empty,
  output tl_pkg::tl_res_t   head
);
  import tl_pkg::*;

  tl_res_t    store_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic       do_pop;

  // room for a full pair keeps the engine simple
  assign room   = (cnt_r <= 3'd2);
  assign empty  = (cnt_r == 3'd0);
  assign head   = store_r[rp_r];
  assign do_pop = pop && !empty;
  assign n_in   = 2'(push.first) + 2'(push.second);

  always_comb begin
    wp_nxt  = wp_r + n_in;
    rp_nxt  = rp_r + 2'(do_pop);
    cnt_nxt = cnt_r + 3'(n_in) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      store_r[wp_r] <= res0;
    end
    if (push.second) begin
      store_r[2'(wp_r + 2'd1)] <= res1;
    end
  end

  // checks
  `TL_ASSERT_NEVER(a_cnt_bound, cnt_r > 3'd4, "result count past depth")
  `TL_ASSERT(a_no_overflow, push.first |-> cnt_r <= 3'd2, "result written without room")
  `TL_ASSERT(a_cnt_step, (!push.first && do_pop) |=> cnt_r == $past(cnt_r) - 3'd1, "result count did not drop on a read")

endmodule

// ===== tb/token_lexer_tb.sv =====
// testbench for the streaming token lexer: directed table, random sources, own predictor
`timescale 1ns / 1ps

module token_lexer_tb;
  import tl_pkg::*;

  // command codes of the input channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // operator kinds, in the order of the operator table
  localparam logic [4:0] KIND_ASSIGN = KIND_OP_BASE + 5'd0;
  localparam logic [4:0] KIND_PLUS   = KIND_OP_BASE + 5'd1;
  localparam logic [4:0] KIND_MINUS  = KIND_OP_BASE + 5'd2;
  localparam logic [4:0] KIND_STAR   = KIND_OP_BASE + 5'd3;
  localparam logic [4:0] KIND_SLASH  = KIND_OP_BASE + 5'd4;
  localparam logic [4:0] KIND_LPAREN = KIND_OP_BASE + 5'd5;
  localparam logic [4:0] KIND_RPAREN = KIND_OP_BASE + 5'd6;
  localparam logic [4:0] KIND_SEMI   = KIND_OP_BASE + 5'd7;

  localparam logic [7:0] OP_CHARS [8] = '{"=", "+", "-", "*", "/", "(", ")", ";"};
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_UNDER = "_";

  // keyword spellings, packed right-justified one byte per letter
  localparam logic [39:0] KW_PRINT = "print";
  localparam logic [39:0] KW_WHILE = "while";
  localparam logic [39:0] KW_IF    = "if";
  localparam logic [39:0] KW_ELSE  = "else";
  localparam logic [39:0] KW_TRUE  = "true";
  localparam logic [39:0] KW_FALSE = "false";
  localparam logic [39:0] KW_LONG  = '1;

  localparam logic [63:0] MANT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_CYCLES  = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic [2:0] {SC_IDLE, SC_STRING, SC_NUMBER, SC_WORD, SC_ERROR} scan_t;

  // one directed row; given rows carry a result read straight off the spec
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       given;
    logic [4:0] kind;
    logic [1:0] err;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{CMD_EOS,  8'h00,    1'b1, KIND_EOF,    ERR_NONE},       // eof straight after reset
    '{CMD_BYTE, "i",      1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, "f",      1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, " ",      1'b0, KIND_EOF,    ERR_NONE},       // closes a keyword
    '{CMD_BYTE, CH_QUOTE, 1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, "a",      1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_QUOTE, 1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, "9",      1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_DOT,   1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, "5",      1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_DOT,   1'b0, KIND_EOF,    ERR_NONE},       // second dot: float then error
    '{CMD_BYTE, "x",      1'b0, KIND_EOF,    ERR_NONE},       // swallowed in error mode
    '{CMD_EOS,  8'h00,    1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, "=",      1'b1, KIND_ASSIGN, ERR_NONE},
    '{CMD_BYTE, "+",      1'b1, KIND_PLUS,   ERR_NONE},
    '{CMD_BYTE, "-",      1'b1, KIND_MINUS,  ERR_NONE},
    '{CMD_BYTE, "*",      1'b1, KIND_STAR,   ERR_NONE},
    '{CMD_BYTE, "/",      1'b1, KIND_SLASH,  ERR_NONE},
    '{CMD_BYTE, "(",      1'b1, KIND_LPAREN, ERR_NONE},
    '{CMD_BYTE, ")",      1'b1, KIND_RPAREN, ERR_NONE},
    '{CMD_BYTE, ";",      1'b1, KIND_SEMI,   ERR_NONE},
    '{CMD_BYTE, 8'hFF,    1'b1, KIND_EOF,    ERR_UNEXPECTED},
    '{CMD_EOS,  8'h00,    1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_QUOTE, 1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_NL,    1'b1, KIND_EOF,    ERR_UNCLOSED},   // newline inside a string
    '{CMD_EOS,  8'h00,    1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_BYTE, CH_QUOTE, 1'b0, KIND_EOF,    ERR_NONE},
    '{CMD_EOS,  8'h00,    1'b1, KIND_EOF,    ERR_UNCLOSED}    // source ends inside a string
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_command = 1'b0;
  logic [7:0]  in_ch = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  out_token_kind;
  logic [1:0]  out_error_code;
  logic [62:0] out_int_value;
  logic [5:0]  out_frac_digits;
  logic        out_bool_value;
  logic [15:0] out_text_start;
  logic [15:0] out_text_length;
  logic        out_last_of_run;

  token_lexer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_command      (in_command),
    .in_ch           (in_ch),
    .empty           (empty),
    .pop             (pop),
    .out_token_kind  (out_token_kind),
    .out_error_code  (out_error_code),
    .out_int_value   (out_int_value),
    .out_frac_digits (out_frac_digits),
    .out_bool_value  (out_bool_value),
    .out_text_start  (out_text_start),
    .out_text_length (out_text_length),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  // lexer state as the predictor sees it
  scan_t       scan;
  logic [15:0] cur_pos;
  logic [15:0] tok_pos;
  logic [62:0] mant;
  logic        has_dot;
  logic [5:0]  frac_cnt;
  logic [39:0] kw_bytes;

  // tokens of the current item, and tokens still owed by the block
  tl_res_t step_res [2];
  int      step_n;
  tl_res_t pending_tokens [$];

  string kw_names [6] = '{"print", "while", "if", "else", "true", "false"};

  int mismatches = 0;
  int rx_count = 0;
  int fed = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int idle_cycles = 0;

  function automatic bit is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return is_alpha(c) || is_decimal(c) || c == CH_UNDER;
  endfunction

  function automatic int op_index(input logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (OP_CHARS[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic tl_res_t make_tok(input logic [4:0] kind, input logic [1:0] err,
                                       input logic [62:0] ival, input logic [5:0] frac,
                                       input logic bval, input logic [15:0] tstart,
                                       input logic [15:0] tlen);
    tl_res_t r;
    r.kind   = kind;
    r.err    = err;
    r.ival   = ival;
    r.frac   = frac;
    r.bval   = bval;
    r.tstart = tstart;
    r.tlen   = tlen;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void lexer_clear();
    scan     = SC_IDLE;
    cur_pos  = '0;
    tok_pos  = '0;
    mant     = '0;
    has_dot  = 1'b0;
    frac_cnt = '0;
    kw_bytes = '0;
  endfunction

  function automatic void add_tok(input tl_res_t t);
    step_res[step_n] = t;
    step_n++;
  endfunction

  function automatic tl_res_t number_tok();
    if (has_dot) return make_tok(KIND_FLOAT, ERR_NONE, mant, frac_cnt, 1'b0, '0, '0);
    return make_tok(KIND_INT, ERR_NONE, mant, '0, 1'b0, '0, '0);
  endfunction

  // identifier, keyword or bool, depending on the letters gathered
  function automatic tl_res_t word_tok();
    logic [4:0] kind;
    logic       bval;
    kind = KIND_ID;
    bval = 1'b0;
    case (kw_bytes)
      KW_PRINT: kind = KIND_PRINT;
      KW_WHILE: kind = KIND_WHILE;
      KW_IF:    kind = KIND_IF;
      KW_ELSE:  kind = KIND_ELSE;
      KW_TRUE: begin
        kind = KIND_BOOL;
        bval = 1'b1;
      end
      KW_FALSE: kind = KIND_BOOL;
      default:  kind = KIND_ID;
    endcase
    return make_tok(kind, ERR_NONE, '0, '0, bval, tok_pos, cur_pos - tok_pos);
  endfunction

  // predictor: tokens caused by one accepted item, state moved on
  function automatic void lex_item(input logic cmd, input logic [7:0] c);
    bit          taken;
    int          op;
    logic [63:0] d;
    step_n = 0;
    taken = 1'b0;
    if (cmd == CMD_EOS) begin
      if (scan == SC_STRING) begin
        add_tok(make_tok(KIND_EOF, ERR_UNCLOSED, '0, '0, 1'b0, '0, '0));
      end else if (scan != SC_ERROR) begin
        if (scan == SC_NUMBER) add_tok(number_tok());
        else if (scan == SC_WORD) add_tok(word_tok());
        add_tok(make_tok(KIND_EOF, ERR_NONE, '0, '0, 1'b0, '0, '0));
      end
      lexer_clear();
    end else if (scan != SC_ERROR) begin
      // continue the open token where the byte allows it
      if (scan == SC_STRING) begin
        taken = 1'b1;
        if (c == CH_QUOTE) begin
          add_tok(make_tok(KIND_STRING, ERR_NONE, '0, '0, 1'b0, tok_pos, cur_pos - tok_pos));
          scan = SC_IDLE;
        end else if (c == CH_NL) begin
          add_tok(make_tok(KIND_EOF, ERR_UNCLOSED, '0, '0, 1'b0, '0, '0));
          scan = SC_ERROR;
        end
      end else if (scan == SC_NUMBER) begin
        if (is_decimal(c)) begin
          d = {56'd0, c - 8'h30};
          if ({1'b0, mant} > (MANT_MAX - d) / 64'd10) mant = MANT_MAX[62:0];
          else mant = 63'(({1'b0, mant} * 64'd10) + d);
          if (has_dot && frac_cnt < 6'd63) frac_cnt = frac_cnt + 6'd1;
          taken = 1'b1;
        end else if (c == CH_DOT && !has_dot) begin
          has_dot = 1'b1;
          taken = 1'b1;
        end else begin
          add_tok(number_tok());
          scan = SC_IDLE;
        end
      end else if (scan == SC_WORD) begin
        if (is_word(c)) begin
          if (kw_bytes < 40'h01_0000_0000 && kw_bytes != '0) kw_bytes = {kw_bytes[31:0], c};
          else kw_bytes = KW_LONG;
          taken = 1'b1;
        end else begin
          add_tok(word_tok());
          scan = SC_IDLE;
        end
      end
      // fresh byte in idle
      if (!taken && !is_space(c)) begin
        op = op_index(c);
        if (c == CH_QUOTE) begin
          scan = SC_STRING;
          tok_pos = cur_pos + 16'd1;
        end else if (is_decimal(c)) begin
          scan = SC_NUMBER;
          mant = 63'(c - 8'h30);
          has_dot = 1'b0;
          frac_cnt = '0;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          scan = SC_WORD;
          tok_pos = cur_pos;
          kw_bytes = {32'd0, c};
        end else if (op >= 0) begin
          add_tok(make_tok(KIND_OP_BASE + 5'(op), ERR_NONE, '0, '0, 1'b0, '0, '0));
        end else begin
          add_tok(make_tok(KIND_EOF, ERR_UNEXPECTED, '0, '0, 1'b0, '0, '0));
          scan = SC_ERROR;
        end
      end
      cur_pos = cur_pos + 16'd1;
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("result %0d: %s expected 0x%0h, got 0x%0h", rx_count, field, want_v, got_v);
  endtask

  // hand one item over, then queue what it should produce
  task automatic drive(input logic cmd, input logic [7:0] ch, input logic given,
                       input logic [4:0] kind, input logic [1:0] err);
    int      gap;
    tl_res_t t;
    gap = tx_quiet ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_command <= cmd;
    in_ch <= ch;
    do @(posedge clk); while (full);
    lex_item(cmd, ch);
    if (given) begin
      t = make_tok(kind, err, '0, '0, 1'b0, '0, '0);
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end else begin
      for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_res[i]);
    end
  endtask

  task automatic feed(input logic cmd, input logic [7:0] ch);
    drive(cmd, ch, 1'b0, KIND_EOF, ERR_NONE);
    fed++;
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] digit_char();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // any byte that keeps a string open
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_NL);
    return c;
  endfunction

  // blank, tab, newline, vertical tab, form feed or carriage return
  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    if (r == 5) return " ";
    return 8'(9 + r);
  endfunction

  // stimulus: directed table, then random sources
  initial begin : stimulus
    int         k, i, n, ntok, pick;
    string      w;
    logic [7:0] c;
    lexer_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++)
      drive(DIR_TAB[k].cmd, DIR_TAB[k].ch, DIR_TAB[k].given, DIR_TAB[k].kind, DIR_TAB[k].err);

    // mostly well-formed sources with random content, some noise and breakage
    while (fed < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      ntok = $urandom_range(1, 12);
      for (k = 0; k < ntok; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
          // keyword, sometimes one letter short or with a tail
          w = kw_names[$urandom_range(0, 5)];
          n = w.len();
          if ($urandom_range(0, 3) == 0) n = n - 1;
          for (i = 0; i < n; i++) feed(CMD_BYTE, w[i]);
          if ($urandom_range(0, 3) == 0) feed(CMD_BYTE, word_char());
        end else if (pick < 32) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
          do c = word_char(); while (is_decimal(c));
          feed(CMD_BYTE, c);
          for (i = 1; i < n; i++) feed(CMD_BYTE, word_char());
        end else if (pick < 46) begin
          // integer, now and then long enough to saturate
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
          for (i = 0; i < n; i++) feed(CMD_BYTE, digit_char());
        end else if (pick < 56) begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) feed(CMD_BYTE, digit_char());
          feed(CMD_BYTE, CH_DOT);
          n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
          for (i = 0; i < n; i++) feed(CMD_BYTE, digit_char());
        end else if (pick < 68) begin
          feed(CMD_BYTE, CH_QUOTE);
          n = $urandom_range(0, 8);
          for (i = 0; i < n; i++) feed(CMD_BYTE, text_char());
          feed(CMD_BYTE, ($urandom_range(0, 9) == 0) ? CH_NL : CH_QUOTE);
        end else if (pick < 84) begin
          feed(CMD_BYTE, OP_CHARS[$urandom_range(0, 7)]);
        end else if (pick < 96) begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) feed(CMD_BYTE, space_char());
        end else begin
          feed(CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        // no separator half the time, so one byte often closes a token
        if ($urandom_range(0, 1) == 0) feed(CMD_BYTE, space_char());
      end
      // source cut off inside a string
      if ($urandom_range(0, 9) == 0) begin
        feed(CMD_BYTE, CH_QUOTE);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) feed(CMD_BYTE, text_char());
      end
      feed(CMD_EOS, 8'($urandom_range(0, 255)));
    end
    push <= 1'b0;

    // drain, then give stray results a chance to show
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random pop stalls, field by field compare
  initial begin : result_sink
    tl_res_t want;
    tl_res_t got;
    int      stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_quiet ? 0 : int'($urandom_range(0, 16));
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.kind   = out_token_kind;
      got.err    = out_error_code;
      got.ival   = out_int_value;
      got.frac   = out_frac_digits;
      got.bval   = out_bool_value;
      got.tstart = out_text_start;
      got.tlen   = out_text_length;
      got.last   = out_last_of_run;
      rx_count++;
      if (rx_count % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (pending_tokens.size() == 0) begin
        report_mismatch("token with nothing pending, kind", '0, 64'(got.kind));
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("token_kind", 64'(want.kind), 64'(got.kind));
        if (got.err !== want.err)
          report_mismatch("error_code", 64'(want.err), 64'(got.err));
        if (got.ival !== want.ival)
          report_mismatch("int_value", 64'(want.ival), 64'(got.ival));
        if (got.frac !== want.frac)
          report_mismatch("frac_digits", 64'(want.frac), 64'(got.frac));
        if (got.bval !== want.bval)
          report_mismatch("bool_value", 64'(want.bval), 64'(got.bval));
        if (got.tstart !== want.tstart)
          report_mismatch("text_start", 64'(want.tstart), 64'(got.tstart));
        if (got.tlen !== want.tlen)
          report_mismatch("text_length", 64'(want.tlen), 64'(got.tlen));
        if (got.last !== want.last)
          report_mismatch("last_of_run", 64'(want.last), 64'(got.last));
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tl_pkg.sv
rtl/tl_front.sv
rtl/tl_engine.sv
rtl/tl_out_queue.sv
rtl/token_lexer.sv
tb/token_lexer_tb.sv
